FILE: design/atb_pkg.sv
// shared constants for the ansi text terminal buffer
package atb_pkg;

    // field widths
    localparam int BYTE_W     = 8;
    localparam int CHAR_W     = 7;
    localparam int ROW_FW     = 5;
    localparam int COL_FW     = 7;
    localparam int ARG_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // default grid geometry
    localparam int DEF_MAX_ROWS = 24;
    localparam int DEF_MAX_COLS = 80;

    // register reset values and indexes
    localparam logic [ROW_FW-1:0]    RESET_ROWS      = 5'd24;
    localparam logic [COL_FW-1:0]    RESET_COLS      = 7'd80;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLS = 1'b1;

    // request kinds
    localparam logic ACT_WRITE = 1'b0;

    // control bytes
    localparam logic [BYTE_W-1:0] CH_BS       = 8'h08;
    localparam logic [BYTE_W-1:0] CH_LF       = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1b;
    localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5b;
    localparam logic [BYTE_W-1:0] CH_SEMI     = 8'h3b;
    localparam logic [BYTE_W-1:0] CH_DIGIT0   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_DIGIT9   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PRINT_HI = 8'h7e;

    // sequence final bytes
    localparam logic [BYTE_W-1:0] CH_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_B = 8'h42;
    localparam logic [BYTE_W-1:0] CH_C = 8'h43;
    localparam logic [BYTE_W-1:0] CH_D = 8'h44;
    localparam logic [BYTE_W-1:0] CH_H = 8'h48;
    localparam logic [BYTE_W-1:0] CH_J = 8'h4a;
    localparam logic [BYTE_W-1:0] CH_K = 8'h4b;

    // stored glyphs
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_CURSOR = 7'h5f;

    // argument handling
    localparam logic [ARG_W-1:0] ARG_MAX   = 8'd255;
    localparam logic [ARG_W-1:0] CLEAR_ARG = 8'd2;
    localparam int               DEC_BASE  = 10;

endpackage

FILE: design/ansi_text_terminal_buffer.sv
// top level of the ansi text terminal buffer: cursor, escape parser and grid sequencer
//
// A character grid of MAX_ROWS x MAX_COLS 7-bit cells with a cursor, driven by
// a byte stream with a small VT100 subset (BS, CR, LF, ESC [ with decimal
// arguments and the finals A B C D H K 2J). Each request either interprets
// data_byte (action 0) or only reads; both return the cell at (read_row,
// read_col) after the request and the cursor position. The grid lives in one
// simple dual-port ram with registered read, and every grid update is a write
// through its single write port, one cell per cycle. After accept a request
// walks its grid work in this order: the old cursor cell, an erase to end of
// line, a full clear, the scroll, the new cursor mark, then the read of the
// result cell, which is offered once the output register is free; the next
// request can be taken as soon as the result is offered. An erase to end of
// line writes one cell per column from the cursor to the right edge; a scroll
// (line feed or wrap on the last row) moves each row below the first up one
// row, then blanks the last row; a full clear (ESC [ 2 J) blanks all
// MAX_ROWS x MAX_COLS cells. After reset the block walks the whole ram
// writing spaces; no request is taken during that pass, while configuration
// writes are. The next request may be taken while a finished result still
// waits in the output register.
module ansi_text_terminal_buffer #(
    parameter int MAX_ROWS = atb_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = atb_pkg::DEF_MAX_COLS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             action,
    input  logic [atb_pkg::BYTE_W-1:0]       data_byte,
    input  logic [atb_pkg::ROW_FW-1:0]       read_row,
    input  logic [atb_pkg::COL_FW-1:0]       read_col,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [atb_pkg::CHAR_W-1:0]       cell_char,
    output logic [atb_pkg::ROW_FW-1:0]       cursor_row,
    output logic [atb_pkg::COL_FW-1:0]       cursor_col,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [atb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [atb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import atb_pkg::*;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // cursor arithmetic: cursor plus a full argument
    localparam int MW    = ARG_W + 1;
    // decimal accumulate before saturation
    localparam int ACC_W = ARG_W + 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUT_OLD,
        ST_LINE_CLR,
        ST_FULL_CLR,
        ST_SCROLL,
        ST_SCROLL_BLANK,
        ST_DRAW,
        ST_READ,
        ST_RESP
    } state_t;

    // grid work still owed for the current request, done in field order
    typedef struct packed {
        logic put_old;
        logic line_clr;
        logic full_clr;
        logic scroll_copy;
        logic scroll_blank;
        logic draw;
        logic read;
    } plan_t;

    function automatic state_t pick(input plan_t p);
        state_t s;
        if (p.put_old)           s = ST_PUT_OLD;
        else if (p.line_clr)     s = ST_LINE_CLR;
        else if (p.full_clr)     s = ST_FULL_CLR;
        else if (p.scroll_copy)  s = ST_SCROLL;
        else if (p.scroll_blank) s = ST_SCROLL_BLANK;
        else if (p.draw)         s = ST_DRAW;
        else if (p.read)         s = ST_READ;
        else                     s = ST_IDLE;
        return s;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    // last usable row / column for a register value, with the size clamped into 1..MAX
    function automatic logic [ROW_W-1:0] rows_lim(input logic [ROW_FW-1:0] v);
        logic [ROW_W-1:0] r;
        if (v == '0)                 r = '0;
        else if (int'(v) > MAX_ROWS) r = ROW_W'(MAX_ROWS - 1);
        else                         r = ROW_W'(v - ROW_FW'(1));
        return r;
    endfunction

    function automatic logic [COL_W-1:0] cols_lim(input logic [COL_FW-1:0] v);
        logic [COL_W-1:0] r;
        if (v == '0)                 r = '0;
        else if (int'(v) > MAX_COLS) r = COL_W'(MAX_COLS - 1);
        else                         r = COL_W'(v - COL_FW'(1));
        return r;
    endfunction

    // control state
    state_t             state_reg, state_next;
    plan_t              plan_reg, plan_next;
    logic [ROW_FW-1:0]  rows_reg, rows_next;
    logic [COL_FW-1:0]  cols_reg, cols_next;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic               esc_reg, esc_next;
    logic               inseq_reg, inseq_next;
    logic [ARG_W-1:0]   argv_reg, argv_next;
    logic [ARG_W-1:0]   argf_reg, argf_next;
    // sweep counters and scroll pipeline
    logic [ROW_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0]   col_cnt_reg, col_cnt_next;
    logic [AW-1:0]      addr_cnt_reg, addr_cnt_next;
    logic               sc_busy_reg, sc_busy_next;
    logic               pend_vld_reg, pend_vld_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    // per-request operands
    logic [CHAR_W-1:0]  put_ch_reg, put_ch_next;
    logic [ROW_W-1:0]   old_row_reg, old_row_next;
    logic [COL_W-1:0]   old_col_reg, old_col_next;
    logic [ROW_W-1:0]   rd_row_reg, rd_row_next;
    logic [COL_W-1:0]   rd_col_reg, rd_col_next;
    logic               rd_hit_reg, rd_hit_next;
    // output register
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic [ROW_FW-1:0]  out_row_reg, out_row_next;
    logic [COL_FW-1:0]  out_col_reg, out_col_next;

    logic [ROW_W-1:0]   rows_m1;
    logic [COL_W-1:0]   cols_m1;

    // grid ram ports
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CHAR_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [CHAR_W-1:0]  mem_rdata;

    atb_ram #(
        .DATA_W (CHAR_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rows_m1 = rows_lim(rows_reg);
    assign cols_m1 = cols_lim(cols_reg);

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cell_char  = out_char_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;

    always_comb
    begin
        logic [MW-1:0]    nrow;
        logic [MW-1:0]    ncol;
        logic [ACC_W-1:0] acc;
        logic [ROW_W-1:0] lim_row;
        logic [COL_W-1:0] lim_col;

        state_next     = state_reg;
        plan_next      = plan_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        esc_next       = esc_reg;
        inseq_next     = inseq_reg;
        argv_next      = argv_reg;
        argf_next      = argf_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        addr_cnt_next  = addr_cnt_reg;
        sc_busy_next   = sc_busy_reg;
        pend_vld_next  = 1'b0;
        pend_addr_next = pend_addr_reg;
        put_ch_next    = put_ch_reg;
        old_row_next   = old_row_reg;
        old_col_next   = old_col_reg;
        rd_row_next    = rd_row_reg;
        rd_col_next    = rd_col_reg;
        rd_hit_next    = rd_hit_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = CHAR_SPACE;
        mem_re    = 1'b0;
        mem_raddr = '0;

        nrow    = MW'(cur_row_reg);
        ncol    = MW'(cur_col_reg);
        acc     = ACC_W'(argv_reg) * ACC_W'(DEC_BASE) + ACC_W'(data_byte[3:0]);
        lim_row = rows_m1;
        lim_col = cols_m1;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // register write: screen size changes, cursor pulled back inside
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_ROWS:
                begin
                    rows_next = cfg_data[ROW_FW-1:0];
                    lim_row   = rows_lim(cfg_data[ROW_FW-1:0]);
                end
                REG_SCREEN_COLS:
                begin
                    cols_next = cfg_data;
                    lim_col   = cols_lim(cfg_data);
                end
                default:
                begin
                end
            endcase
            if (cur_row_reg > lim_row) cur_row_next = lim_row;
            if (cur_col_reg > lim_col) cur_col_next = lim_col;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // decode the request into cursor update and a grid plan
                    plan_next      = '0;
                    plan_next.read = 1'b1;
                    put_ch_next    = CHAR_SPACE;
                    old_row_next   = cur_row_reg;
                    old_col_next   = cur_col_reg;
                    rd_hit_next    = (int'(read_row) < MAX_ROWS) && (int'(read_col) < MAX_COLS);
                    rd_row_next    = ROW_W'(read_row);
                    rd_col_next    = COL_W'(read_col);
                    row_cnt_next   = '0;
                    col_cnt_next   = '0;
                    addr_cnt_next  = '0;
                    sc_busy_next   = 1'b0;

                    if (action == ACT_WRITE)
                    begin
                        plan_next.draw = 1'b1;
                        case (data_byte)
                            CH_BS:
                            begin
                                plan_next.put_old = 1'b1;
                                if (cur_col_reg == '0)
                                begin
                                    // wrap back to end of previous row, stay at top-left
                                    if (cur_row_reg != '0)
                                    begin
                                        nrow = nrow - MW'(1);
                                        ncol = MW'(cols_m1);
                                    end
                                end
                                else
                                begin
                                    ncol = ncol - MW'(1);
                                end
                            end
                            CH_CR:
                            begin
                                plan_next.put_old = 1'b1;
                                plan_next.draw    = 1'b0;
                                ncol              = '0;
                            end
                            CH_LF:
                            begin
                                nrow = nrow + MW'(1);
                            end
                            CH_ESC:
                            begin
                                esc_next       = 1'b1;
                                plan_next.draw = 1'b0;
                            end
                            default:
                            begin
                                if (esc_reg)
                                begin
                                    esc_next = 1'b0;
                                end
                                if (esc_reg && data_byte == CH_LBRACKET)
                                begin
                                    // csi opener
                                    inseq_next     = 1'b1;
                                    plan_next.draw = 1'b0;
                                end
                                else if (inseq_reg)
                                begin
                                    if (data_byte inside {[CH_DIGIT0:CH_DIGIT9]})
                                    begin
                                        argv_next = (acc > ACC_W'(ARG_MAX)) ? ARG_MAX
                                                                            : ARG_W'(acc);
                                    end
                                    else if (data_byte == CH_SEMI)
                                    begin
                                        argf_next = argv_reg;
                                        argv_next = '0;
                                    end
                                    else
                                    begin
                                        // final byte
                                        case (data_byte)
                                            CH_K:
                                            begin
                                                plan_next.line_clr = 1'b1;
                                                col_cnt_next       = cur_col_reg;
                                            end
                                            CH_J:
                                            begin
                                                if (argv_reg == CLEAR_ARG)
                                                begin
                                                    plan_next.full_clr = 1'b1;
                                                    nrow               = '0;
                                                    ncol               = '0;
                                                end
                                            end
                                            CH_A:
                                            begin
                                                plan_next.put_old = 1'b1;
                                                nrow = (MW'(argv_reg) > nrow) ? '0
                                                                              : nrow - MW'(argv_reg);
                                            end
                                            CH_B:
                                            begin
                                                plan_next.put_old = 1'b1;
                                                nrow = nrow + MW'(argv_reg);
                                            end
                                            CH_C:
                                            begin
                                                plan_next.put_old = 1'b1;
                                                ncol = ncol + MW'(argv_reg);
                                            end
                                            CH_D:
                                            begin
                                                plan_next.put_old = 1'b1;
                                                ncol = (MW'(argv_reg) > ncol) ? '0
                                                                              : ncol - MW'(argv_reg);
                                            end
                                            CH_H:
                                            begin
                                                plan_next.put_old = 1'b1;
                                                nrow = MW'(argf_reg);
                                                ncol = MW'(argv_reg);
                                            end
                                            default:
                                            begin
                                            end
                                        endcase
                                        if (nrow > MW'(rows_m1)) nrow = MW'(rows_m1);
                                        if (ncol > MW'(cols_m1)) ncol = MW'(cols_m1);
                                        argv_next  = '0;
                                        argf_next  = '0;
                                        inseq_next = 1'b0;
                                    end
                                end
                                else
                                begin
                                    esc_next   = 1'b0;
                                    inseq_next = 1'b0;
                                    argv_next  = '0;
                                    argf_next  = '0;
                                    if (data_byte inside {[CH_PRINT_LO:CH_PRINT_HI]})
                                    begin
                                        plan_next.put_old = 1'b1;
                                        put_ch_next       = data_byte[CHAR_W-1:0];
                                        if (ncol == MW'(cols_m1))
                                        begin
                                            ncol = '0;
                                            nrow = nrow + MW'(1);
                                        end
                                        else
                                        begin
                                            ncol = ncol + MW'(1);
                                        end
                                    end
                                end
                            end
                        endcase

                        // moved past the last row: scroll up one row
                        if (nrow > MW'(rows_m1))
                        begin
                            nrow                   = MW'(rows_m1);
                            plan_next.scroll_blank = 1'b1;
                            plan_next.scroll_copy  = (rows_m1 != '0);
                            sc_busy_next           = (rows_m1 != '0);
                        end
                    end

                    cur_row_next = ROW_W'(nrow);
                    cur_col_next = COL_W'(ncol);
                    state_next   = pick(plan_next);
                end
            end

            ST_PUT_OLD:
            begin
                mem_we            = 1'b1;
                mem_waddr         = cell_addr(old_row_reg, old_col_reg);
                mem_wdata         = put_ch_reg;
                plan_next.put_old = 1'b0;
                state_next        = pick(plan_next);
            end

            ST_LINE_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(old_row_reg, col_cnt_reg);
                if (col_cnt_reg == cols_m1)
                begin
                    plan_next.line_clr = 1'b0;
                    state_next         = pick(plan_next);
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + COL_W'(1);
                end
            end

            ST_FULL_CLR:
            begin
                // also the clearing pass after reset
                mem_we    = 1'b1;
                mem_waddr = addr_cnt_reg;
                if (addr_cnt_reg == AW'(DEPTH - 1))
                begin
                    addr_cnt_next      = '0;
                    plan_next.full_clr = 1'b0;
                    state_next         = pick(plan_next);
                end
                else
                begin
                    addr_cnt_next = addr_cnt_reg + AW'(1);
                end
            end

            ST_SCROLL:
            begin
                // read row j+1 while writing the previous read into row j
                if (pend_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    mem_wdata = mem_rdata;
                end
                if (sc_busy_reg)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = cell_addr(row_cnt_reg + ROW_W'(1), col_cnt_reg);
                    pend_vld_next  = 1'b1;
                    pend_addr_next = cell_addr(row_cnt_reg, col_cnt_reg);
                    if (col_cnt_reg == cols_m1)
                    begin
                        col_cnt_next = '0;
                        if (row_cnt_reg == rows_m1 - ROW_W'(1))
                        begin
                            sc_busy_next = 1'b0;
                        end
                        else
                        begin
                            row_cnt_next = row_cnt_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        col_cnt_next = col_cnt_reg + COL_W'(1);
                    end
                end
                else
                begin
                    plan_next.scroll_copy = 1'b0;
                    state_next            = pick(plan_next);
                end
            end

            ST_SCROLL_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(rows_m1, col_cnt_reg);
                if (col_cnt_reg == cols_m1)
                begin
                    col_cnt_next           = '0;
                    plan_next.scroll_blank = 1'b0;
                    state_next             = pick(plan_next);
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + COL_W'(1);
                end
            end

            ST_DRAW:
            begin
                mem_we         = 1'b1;
                mem_waddr      = cell_addr(cur_row_reg, cur_col_reg);
                mem_wdata      = CHAR_CURSOR;
                plan_next.draw = 1'b0;
                state_next     = pick(plan_next);
            end

            ST_READ:
            begin
                mem_re         = rd_hit_reg;
                mem_raddr      = cell_addr(rd_row_reg, rd_col_reg);
                plan_next.read = 1'b0;
                state_next     = ST_RESP;
            end

            ST_RESP:
            begin
                // ram output holds until the next read, so waiting here is safe
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = rd_hit_reg ? mem_rdata : CHAR_SPACE;
                    out_row_next   = ROW_FW'(cur_row_reg);
                    out_col_next   = COL_FW'(cur_col_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FULL_CLR;
            plan_reg      <= '0;
            rows_reg      <= RESET_ROWS;
            cols_reg      <= RESET_COLS;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            esc_reg       <= 1'b0;
            inseq_reg     <= 1'b0;
            argv_reg      <= '0;
            argf_reg      <= '0;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            addr_cnt_reg  <= '0;
            sc_busy_reg   <= 1'b0;
            pend_vld_reg  <= 1'b0;
            pend_addr_reg <= '0;
            put_ch_reg    <= CHAR_SPACE;
            old_row_reg   <= '0;
            old_col_reg   <= '0;
            rd_row_reg    <= '0;
            rd_col_reg    <= '0;
            rd_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= CHAR_SPACE;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            plan_reg      <= plan_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            esc_reg       <= esc_next;
            inseq_reg     <= inseq_next;
            argv_reg      <= argv_next;
            argf_reg      <= argf_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            addr_cnt_reg  <= addr_cnt_next;
            sc_busy_reg   <= sc_busy_next;
            pend_vld_reg  <= pend_vld_next;
            pend_addr_reg <= pend_addr_next;
            put_ch_reg    <= put_ch_next;
            old_row_reg   <= old_row_next;
            old_col_reg   <= old_col_next;
            rd_row_reg    <= rd_row_next;
            rd_col_reg    <= rd_col_next;
            rd_hit_reg    <= rd_hit_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
        end
    end

endmodule

FILE: design/atb_ram.sv
// simple dual-port ram with registered read
module atb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
